[rtl/assert_macros.svh]
// Assertion helpers, clocked on i_clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/spv_pkg.sv]
// ----------------------------------------------------------------------------
// spv_pkg
// Shared constants, types and the J0 series function for the phase-velocity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spv_pkg;

    localparam int BISECT_STEPS_DEF   = 20;
    localparam int J0_TABLE_DEPTH_DEF = 1024;
    localparam int ARG_FRAC_BITS_DEF  = 20;

    localparam logic [63:0] KRMAX_Q30  = 64'd4114262958;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [63:0] XMIN_Q30   = 64'd1073742;
    localparam logic [63:0] ONE_Q30    = 64'd1073741824;
    localparam logic [23:0] VEL_MAX    = 24'hFFFFFF;
    localparam logic [13:0] MM_SCALE   = 14'd16000;

    localparam int DIV_STEPS = 24;
    localparam int PIPE_LAT  = 8;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_RADIUS = 3'd0;
    localparam logic [23:0] RADIUS_RST = 24'd1000;

    typedef enum logic [1:0] {
        KIND_IN_RANGE = 2'd0,
        KIND_AT_ONE   = 2'd1,
        KIND_AT_MIN   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIS,
        S_VX,
        S_VM0,
        S_VM1,
        S_VCMP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic bis_upd;
        logic fin_x;
        logic mul0;
        logic mul1;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic out_valid;
    } t_dp_sts;

    // J0 by power series in Q1.30, x in Q30
    function automatic logic signed [31:0] f_series_j0(input logic [63:0] x);
        logic [63:0]        q;
        logic [63:0]        t;
        logic signed [63:0] s;
        q = (x * x) >> 32;
        t = ONE_Q30;
        s = signed'(ONE_Q30);
        for (int k = 1; k <= 64; k++) begin
            if (t != 64'd0) begin
                t = ((t * q) >> 30) / 64'(k * k);
                if ((k & 1) == 1)
                    s = s - signed'(t);
                else
                    s = s + signed'(t);
            end
        end
        return s[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/spv_ctrl.sv]
// ----------------------------------------------------------------------------
// spv_ctrl
// Sequencer: bisection steps, velocity product, division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spv_ctrl #(
    parameter int BISECT_STEPS = spv_pkg::BISECT_STEPS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire spv_pkg::t_dp_sts i_sts,
    output spv_pkg::t_dp_cmd      o_cmd
);

    localparam int CW = $clog2(spv_pkg::DIV_STEPS + 1);
    localparam int SW = $clog2(BISECT_STEPS + 1);

    spv_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic [SW-1:0]   r_step;
    logic            w_wait_done;
    logic            w_last_step;

    assign w_wait_done = (r_cnt == CW'(spv_pkg::PIPE_LAT));
    assign w_last_step = (r_step == SW'(BISECT_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spv_pkg::S_IDLE: if (i_in_valid) n_state = spv_pkg::S_BIS;
            spv_pkg::S_BIS:  if (w_wait_done && w_last_step) n_state = spv_pkg::S_VX;
            spv_pkg::S_VX:   n_state = spv_pkg::S_VM0;
            spv_pkg::S_VM0:  n_state = spv_pkg::S_VM1;
            spv_pkg::S_VM1:  n_state = spv_pkg::S_VCMP;
            spv_pkg::S_VCMP: n_state = spv_pkg::S_DIV;
            spv_pkg::S_DIV: begin
                if (r_cnt == CW'(spv_pkg::DIV_STEPS - 1)) n_state = spv_pkg::S_DONE;
            end
            spv_pkg::S_DONE: if (i_sts.out_free) n_state = spv_pkg::S_IDLE;
            default:         n_state = spv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            spv_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            spv_pkg::S_BIS:  o_cmd.bis_upd  = w_wait_done;
            spv_pkg::S_VX:   o_cmd.fin_x    = 1'b1;
            spv_pkg::S_VM0:  o_cmd.mul0     = 1'b1;
            spv_pkg::S_VM1:  o_cmd.mul1     = 1'b1;
            spv_pkg::S_VCMP: o_cmd.div_init = 1'b1;
            spv_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            spv_pkg::S_DONE: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spv_pkg::S_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state)
                r_cnt <= '0;
            else if (r_state == spv_pkg::S_BIS)
                r_cnt <= w_wait_done ? '0 : r_cnt + 1'b1;
            else
                r_cnt <= r_cnt + 1'b1;
            if (r_state == spv_pkg::S_IDLE)
                r_step <= '0;
            else if (r_state == spv_pkg::S_BIS && w_wait_done)
                r_step <= r_step + 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/spv_dp.sv]
// ----------------------------------------------------------------------------
// spv_dp
// Datapath: J0 table lookup pipeline, bisection registers, velocity divider.
// ----------------------------------------------------------------------------
`default_nettype none

module spv_dp #(
    parameter int J0_TABLE_DEPTH = spv_pkg::J0_TABLE_DEPTH_DEF,
    parameter int ARG_FRAC_BITS  = spv_pkg::ARG_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spv_pkg::t_dp_cmd   i_cmd,
    output spv_pkg::t_dp_sts        o_sts,
    input  wire logic [23:0]        i_frequency,
    input  wire logic signed [15:0] i_coefficient,
    input  wire logic [23:0]        i_radius,
    input  wire logic               i_out_ready,
    output logic [23:0]             o_velocity,
    output logic                    o_saturated,
    output logic [1:0]              o_clamp_kind
);

    typedef logic signed [31:0] t_rom [J0_TABLE_DEPTH];

    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] xs;
        for (int i = 0; i < J0_TABLE_DEPTH; i++) begin
            xs = (64'(i) * spv_pkg::KRMAX_Q30) / 64'(J0_TABLE_DEPTH - 1);
            rom[i] = spv_pkg::f_series_j0(xs);
        end
        return rom;
    endfunction

    localparam t_rom ROM = f_build_rom();

    function automatic logic [63:0] f_max_diff();
        logic [63:0]        m;
        logic signed [63:0] d;
        m = 64'd1;
        for (int i = 0; i < J0_TABLE_DEPTH - 1; i++) begin
            d = 64'(ROM[i+1]) - 64'(ROM[i]);
            if (d < 0) d = -d;
            if (64'(d) > m) m = 64'(d);
        end
        return m;
    endfunction

    localparam int SHIFT = 30 - ARG_FRAC_BITS;
    localparam logic [63:0] KR_ARG =
        (spv_pkg::KRMAX_Q30 + ((64'd1 << SHIFT) >> 1)) >> SHIFT;
    localparam logic [63:0] XMIN_ARG =
        (spv_pkg::XMIN_Q30 + ((64'd1 << SHIFT) >> 1)) >> SHIFT;
    localparam int XW  = $clog2(KR_ARG + 1);
    localparam int IW  = $clog2(J0_TABLE_DEPTH);
    localparam int PW  = $clog2(KR_ARG * 64'(J0_TABLE_DEPTH - 1) + 1);
    localparam logic [63:0] R1 = (64'd1 << PW) / KR_ARG;
    localparam logic [63:0] MAXD = f_max_diff();
    localparam int MW  = $clog2(MAXD + 1);
    localparam int PRW = MW + XW;
    localparam logic [63:0] R2 = (64'd1 << PRW) / KR_ARG;
    localparam logic signed [32:0] ROM_LAST = 33'(ROM[J0_TABLE_DEPTH-1]);
    localparam logic signed [32:0] ROM_FIRST = 33'(ROM[0]);
    localparam logic signed [32:0] ONE_T = 33'(spv_pkg::ONE_Q30);
    localparam int XQW = XW + SHIFT;
    localparam int DNW = XQW + 14;
    localparam int NW  = 81;
    localparam int DV  = spv_pkg::DIV_STEPS;

    // bisection state
    logic [XW-1:0]        r_lo, r_hi;
    logic signed [32:0]   r_target, r_jlo;
    logic [1:0]           r_kind;
    logic [23:0]          r_freq;
    logic [XW:0]          w_sum;
    logic [XW-1:0]        w_mid;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[XW:1];

    // lookup pipeline, runs every cycle on w_mid
    logic [PW-1:0]        r_p, r_p1;
    logic [IW-1:0]        r_e1;
    logic [PW+IW-1:0]     w_prod1;
    logic [PW-1:0]        w_rm1;
    logic [XW:0]          r_rm1;
    logic [IW-1:0]        r_e1b;
    logic [IW-1:0]        w_idx, w_idx_b;
    logic [XW:0]          w_rem_c;
    logic signed [31:0]   r_a, r_b;
    logic [XW-1:0]        r_rem;
    logic                 r_last, r_last2, r_last3, r_last4;
    logic signed [32:0]   w_d;
    logic [MW-1:0]        w_dabs;
    logic [PRW-1:0]       r_n2, r_n2b;
    logic                 r_neg, r_neg2, r_neg3;
    logic signed [31:0]   r_a2, r_a3, r_a4;
    logic [PRW+MW-1:0]    w_prod2;
    logic [MW-1:0]        r_e2, r_e2b;
    logic [PRW-1:0]       r_rm2;
    logic [MW-1:0]        w_q;
    logic signed [32:0]   r_val;

    assign w_prod1 = (PW+IW)'(r_p) * (PW+IW)'(R1);
    assign w_rm1   = r_p1 - PW'((XW+IW)'(r_e1) * (XW+IW)'(KR_ARG));
    assign w_idx   = (r_rm1 >= (XW+1)'(KR_ARG)) ? r_e1b + 1'b1 : r_e1b;
    assign w_rem_c = (r_rm1 >= (XW+1)'(KR_ARG)) ? r_rm1 - (XW+1)'(KR_ARG) : r_rm1;
    assign w_idx_b = (w_idx == IW'(J0_TABLE_DEPTH - 1)) ? w_idx : w_idx + 1'b1;
    assign w_d     = 33'(r_b) - 33'(r_a);
    assign w_dabs  = w_d[32] ? MW'(-w_d) : MW'(w_d);
    assign w_prod2 = (PRW+MW)'(r_n2) * (PRW+MW)'(R2);
    assign w_q     = (r_rm2 >= PRW'(KR_ARG)) ? r_e2b + 1'b1 : r_e2b;

    always_ff @(posedge i_clk) begin
        r_p     <= PW'(w_mid) * PW'(J0_TABLE_DEPTH - 1);
        r_e1    <= w_prod1[PW+IW-1:PW];
        r_p1    <= r_p;
        r_rm1   <= (XW+1)'(w_rm1);
        r_e1b   <= r_e1;
        r_a     <= ROM[w_idx];
        r_b     <= ROM[w_idx_b];
        r_rem   <= XW'(w_rem_c);
        r_last  <= (w_idx == IW'(J0_TABLE_DEPTH - 1));
        r_n2    <= PRW'(w_dabs) * PRW'(r_rem);
        r_neg   <= w_d[32];
        r_a2    <= r_a;
        r_last2 <= r_last;
        r_e2    <= w_prod2[PRW+MW-1:PRW];
        r_n2b   <= r_n2;
        r_neg2  <= r_neg;
        r_a3    <= r_a2;
        r_last3 <= r_last2;
        r_rm2   <= r_n2b - PRW'(r_e2) * PRW'(KR_ARG);
        r_e2b   <= r_e2;
        r_neg3  <= r_neg2;
        r_a4    <= r_a3;
        r_last4 <= r_last3;
        if (r_last4)
            r_val <= ROM_LAST;
        else if (r_neg3)
            r_val <= 33'(r_a4) - 33'(w_q);
        else
            r_val <= 33'(r_a4) + 33'(w_q);
    end

    // bisection update
    logic signed [32:0] w_cq;
    logic signed [33:0] w_dm, w_dl;
    logic               w_go_hi;

    assign w_cq    = {i_coefficient[15], i_coefficient, 16'd0};
    assign w_dm    = 34'(r_val) - 34'(r_target);
    assign w_dl    = 34'(r_jlo) - 34'(r_target);
    assign w_go_hi = (w_dm == '0) || (w_dl == '0) || (w_dm[33] != w_dl[33]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo   <= '0;
            r_hi   <= XW'(KR_ARG);
            r_jlo  <= ROM_FIRST;
            r_freq <= i_frequency;
            priority if (w_cq >= ONE_T) begin
                r_target <= ONE_T;
                r_kind   <= spv_pkg::KIND_AT_ONE;
            end else if (w_cq <= ROM_LAST) begin
                r_target <= ROM_LAST;
                r_kind   <= spv_pkg::KIND_AT_MIN;
            end else begin
                r_target <= w_cq;
                r_kind   <= spv_pkg::KIND_IN_RANGE;
            end
        end else if (i_cmd.bis_upd) begin
            if (w_go_hi) begin
                r_hi <= w_mid;
            end else begin
                r_lo  <= w_mid;
                r_jlo <= r_val;
            end
        end
    end

    // velocity: num = f*r*2pi, den = x*16000, quotient saturates at 24 bits
    logic [XW-1:0]  r_x;
    logic           r_tiny;
    logic [47:0]    r_fr;
    logic [63:0]    r_pp0;
    logic [DNW-1:0] r_den;
    logic [NW-1:0]  r_num;
    logic           r_over;
    logic [DNW-1:0] r_rem_d;
    logic [DV-1:0]  r_nlo;
    logic [23:0]    r_q;
    logic [DNW:0]   w_t;
    logic           w_qb;
    logic [NW-1:0]  w_den_hi;

    assign w_t      = {r_rem_d, r_nlo[DV-1]};
    assign w_qb     = (w_t >= (DNW+1)'(r_den));
    assign w_den_hi = NW'(r_den) << DV;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_x) begin
            r_x    <= w_mid;
            r_tiny <= (64'(w_mid) < XMIN_ARG);
            r_fr   <= 48'(r_freq) * 48'(i_radius);
        end
        if (i_cmd.mul0) begin
            r_pp0 <= 64'(r_fr) * 64'(spv_pkg::TWO_PI_Q30[15:0]);
            r_den <= DNW'(XQW'(r_x) << SHIFT) * DNW'(spv_pkg::MM_SCALE);
        end
        if (i_cmd.mul1)
            r_num <= NW'(r_pp0) + (NW'(65'(r_fr) * 65'(spv_pkg::TWO_PI_Q30[32:16])) << 16);
        if (i_cmd.div_init) begin
            r_over  <= (r_num >= w_den_hi);
            r_rem_d <= DNW'(r_num[NW-1:DV]);
            r_nlo   <= r_num[DV-1:0];
            r_q     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_d <= w_qb ? DNW'(w_t - (DNW+1)'(r_den)) : DNW'(w_t);
            r_nlo   <= r_nlo << 1;
            r_q     <= {r_q[22:0], w_qb};
        end
    end

    // output register
    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_velocity   <= (r_tiny || r_over) ? spv_pkg::VEL_MAX : r_q;
            o_saturated  <= r_tiny || r_over;
            o_clamp_kind <= r_kind;
        end
    end

    assign o_sts.out_valid = r_ov;
    assign o_sts.out_free  = !r_ov || i_out_ready;

endmodule

`default_nettype wire

[rtl/spac_phase_velocity_unit.sv]
// ----------------------------------------------------------------------------
// spac_phase_velocity_unit
// SPAC coefficient to phase velocity by bisection on a tabulated J0.
// ----------------------------------------------------------------------------
// One item in, one result out. Each bisection step waits for the 8-stage J0
// lookup pipeline (table read, interpolation and two constant divides), then
// the velocity needs a split 48x33 product and a restoring divide to a 24-bit
// quotient. The final hand-off state stretches while an earlier result still
// waits. A new item is taken while the previous result still waits in the
// output register. The radius register sits at byte address 0.
`default_nettype none

`include "assert_macros.svh"

module spac_phase_velocity_unit #(
    parameter int BISECT_STEPS   = spv_pkg::BISECT_STEPS_DEF,
    parameter int J0_TABLE_DEPTH = spv_pkg::J0_TABLE_DEPTH_DEF,
    parameter int ARG_FRAC_BITS  = spv_pkg::ARG_FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [39:0]                 s_axis_tdata,  // frequency[23:0], coefficient[39:24]
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // velocity[23:0]
    output logic [2:0]                       m_axis_tuser,  // saturated[0], clamp_kind[2:1]
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [spv_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [23:0]      r_radius;
    spv_pkg::t_dp_cmd w_cmd;
    spv_pkg::t_dp_sts w_sts;
    logic [23:0]      w_vel;
    logic             w_sat;
    logic [1:0]       w_kind;

    assign pready = 1'b1;
    assign prdata = (paddr == spv_pkg::ADDR_RADIUS) ? {8'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= spv_pkg::RADIUS_RST;
        end else if (psel && penable && pwrite && paddr == spv_pkg::ADDR_RADIUS) begin
            r_radius <= pwdata[23:0];
        end
    end

    spv_ctrl #(
        .BISECT_STEPS(BISECT_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    spv_dp #(
        .J0_TABLE_DEPTH(J0_TABLE_DEPTH),
        .ARG_FRAC_BITS (ARG_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_frequency   (s_axis_tdata[23:0]),
        .i_coefficient (s_axis_tdata[39:24]),
        .i_radius      (r_radius),
        .i_out_ready   (m_axis_tready),
        .o_velocity    (w_vel),
        .o_saturated   (w_sat),
        .o_clamp_kind  (w_kind)
    );

    assign m_axis_tvalid = w_sts.out_valid;
    assign m_axis_tdata  = w_vel;
    assign m_axis_tuser  = {w_kind, w_sat};

    `ASSERT_SAME(a_sat_full, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == spv_pkg::VEL_MAX)
    `ASSERT_SAME(a_kind_code, m_axis_tvalid, m_axis_tuser[2:1] != 2'd3)
    `ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_NEXT(a_no_result_early, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)

endmodule

`default_nettype wire
